// ----- rtl/bla_pkg.sv -----
// Shared types, sizes and codes for the binary lifting ancestor table.
// Used by bla_ctrl and binary_lifting_ancestor_table_top; depends on nothing.
`timescale 1ns / 1ps

package bla_pkg;

	// Table sizes.
	localparam int MAX_NODES = 1024;
	localparam int LEVELS    = 10;

	// Derived widths.
	localparam int NODE_W = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
	localparam int CNT_W  = $clog2(MAX_NODES + 1);
	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int DEP_W  = NODE_W;
	localparam int JADR_W = NODE_W + LVL_W;
	localparam int JDEPTH = MAX_NODES * (2 ** LVL_W);

	// Fixed field widths of the item formats.
	localparam int ACT_W  = 2;
	localparam int IDX_W  = 10;
	localparam int STAT_W = 2;

	// Action codes.
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

	// One input item.
	typedef struct packed {
		logic [IDX_W-1:0] lower_node;
		logic [IDX_W-1:0] upper_node;
		logic [ACT_W-1:0] action;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  new_node;
		logic              is_ancestor;
	} res_t;

	// Request to the jump table memory.
	typedef struct packed {
		logic              we;
		logic [JADR_W-1:0] waddr;
		logic [NODE_W-1:0] wdata;
		logic [JADR_W-1:0] raddr;
	} jreq_t;

	// Request to the depth memory.
	typedef struct packed {
		logic              we;
		logic [NODE_W-1:0] waddr;
		logic [DEP_W-1:0]  wdata;
		logic [NODE_W-1:0] raddr;
	} dreq_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_INS_DWR,
		S_INS_JWR,
		S_Q_DL,
		S_Q_DIF,
		S_Q_LIFT,
		S_Q_WAIT,
		S_Q_CMP,
		S_DONE
	} state_t;

endpackage

// ----- rtl/bla_ram.sv -----
// Generic simple dual-port RAM: one write port and one registered read port.
// Self-contained; instantiated for the jump table and the depth table.
`timescale 1ns / 1ps

module bla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/bla_ctrl.sv -----
// Sequencer and datapath: decodes an item and walks the jump table one level per step.
// Depends on bla_pkg; drives the jump and depth memories instantiated in the top level.
`timescale 1ns / 1ps

module bla_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  bla_pkg::item_t             in_item,
	output logic                       res_valid,
	input  logic                       res_ready,
	output bla_pkg::res_t              res,
	output bla_pkg::jreq_t             jreq,
	input  logic [bla_pkg::NODE_W-1:0] jrdata,
	output bla_pkg::dreq_t             dreq,
	input  logic [bla_pkg::DEP_W-1:0]  drdata
);

	bla_pkg::state_t                state_q, state_d;
	bla_pkg::item_t                 item_q;
	bla_pkg::res_t                  res_q, res_d;
	logic [bla_pkg::CNT_W-1:0]      count_q, count_d;
	logic [bla_pkg::LVL_W-1:0]      lv_q, lv_d;
	logic [bla_pkg::NODE_W-1:0]     node_q, node_d;
	logic [bla_pkg::DEP_W-1:0]      du_q, du_d;
	logic [bla_pkg::LEVELS-1:0]     dist_q, dist_d;
	logic                           jzero_q, jzero_d;
	logic                           dzero_q, dzero_d;
	logic [bla_pkg::NODE_W-1:0]     jdata;
	logic [bla_pkg::DEP_W-1:0]      ddata;
	logic [bla_pkg::NODE_W-1:0]     upper;
	logic [bla_pkg::NODE_W-1:0]     lower;
	logic [bla_pkg::NODE_W-1:0]     row;
	logic                           upper_bad;
	logic                           lower_bad;
	logic [bla_pkg::DEP_W-1:0]      diff;

	// The root row and root depth read as zero without ever being stored.
	assign jdata = jzero_q ? '0 : jrdata;
	assign ddata = dzero_q ? '0 : drdata;

	assign upper = bla_pkg::NODE_W'(item_q.upper_node);
	assign lower = bla_pkg::NODE_W'(item_q.lower_node);
	assign row   = count_q[bla_pkg::NODE_W-1:0];
	assign upper_bad = (bla_pkg::CNT_W'(item_q.upper_node) >= count_q);
	assign lower_bad = (bla_pkg::CNT_W'(item_q.lower_node) >= count_q);
	assign diff  = ddata - du_q;

	assign in_ready  = (state_q == bla_pkg::S_IDLE);
	assign res_valid = (state_q == bla_pkg::S_DONE);
	assign res       = res_q;

	// State and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bla_pkg::S_IDLE;
			count_q <= bla_pkg::CNT_W'(1);
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_item;
		end
		res_q   <= res_d;
		lv_q    <= lv_d;
		node_q  <= node_d;
		du_q    <= du_d;
		dist_q  <= dist_d;
		jzero_q <= jzero_d;
		dzero_q <= dzero_d;
	end

	// Next state, memory requests and result.
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		res_d   = res_q;
		lv_d    = lv_q;
		node_d  = node_q;
		du_d    = du_q;
		dist_d  = dist_q;
		jreq    = '0;
		dreq    = '0;
		jzero_d = 1'b0;
		dzero_d = 1'b0;

		unique case (state_q)
			bla_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = bla_pkg::S_DECODE;
				end
			end

			bla_pkg::S_DECODE: begin
				res_d   = '0;
				state_d = bla_pkg::S_DONE;
				case (item_q.action)
					bla_pkg::ACT_INSERT: begin
						if (count_q == bla_pkg::CNT_W'(bla_pkg::MAX_NODES)) begin
							res_d.status = bla_pkg::ST_FULL;
						end else if (upper_bad) begin
							res_d.status = bla_pkg::ST_BAD;
						end else begin
							// Level 0 is the parent itself; fetch the parent's depth.
							jreq.we    = 1'b1;
							jreq.waddr = {row, bla_pkg::LVL_W'(0)};
							jreq.wdata = upper;
							dreq.raddr = upper;
							dzero_d    = (upper == '0);
							state_d    = bla_pkg::S_INS_DWR;
						end
					end
					bla_pkg::ACT_QUERY: begin
						if (upper_bad || lower_bad) begin
							res_d.status = bla_pkg::ST_BAD;
						end else begin
							dreq.raddr = upper;
							dzero_d    = (upper == '0);
							state_d    = bla_pkg::S_Q_DL;
						end
					end
					bla_pkg::ACT_CLEAR: begin
						count_d = bla_pkg::CNT_W'(1);
					end
					default: begin
					end
				endcase
			end

			bla_pkg::S_INS_DWR: begin
				// Store the new depth and start the walk up the parent's rows.
				dreq.we    = 1'b1;
				dreq.waddr = row;
				dreq.wdata = ddata + bla_pkg::DEP_W'(1);
				if (bla_pkg::LEVELS > 1) begin
					jreq.raddr = {upper, bla_pkg::LVL_W'(0)};
					jzero_d    = (upper == '0);
					lv_d       = bla_pkg::LVL_W'(1);
					state_d    = bla_pkg::S_INS_JWR;
				end else begin
					res_d.new_node = bla_pkg::IDX_W'(row);
					count_d        = count_q + bla_pkg::CNT_W'(1);
					state_d        = bla_pkg::S_DONE;
				end
			end

			bla_pkg::S_INS_JWR: begin
				// Entry lv is entry lv-1 of the ancestor found one level down.
				jreq.we    = 1'b1;
				jreq.waddr = {row, lv_q};
				jreq.wdata = jdata;
				if (lv_q == bla_pkg::LVL_W'(bla_pkg::LEVELS - 1)) begin
					res_d.new_node = bla_pkg::IDX_W'(row);
					count_d        = count_q + bla_pkg::CNT_W'(1);
					state_d        = bla_pkg::S_DONE;
				end else begin
					jreq.raddr = {jdata, lv_q};
					jzero_d    = (jdata == '0);
					lv_d       = lv_q + bla_pkg::LVL_W'(1);
				end
			end

			bla_pkg::S_Q_DL: begin
				du_d       = ddata;
				dreq.raddr = lower;
				dzero_d    = (lower == '0);
				state_d    = bla_pkg::S_Q_DIF;
			end

			bla_pkg::S_Q_DIF: begin
				// Upper deeper than lower cannot be an ancestor.
				if (ddata < du_q) begin
					state_d = bla_pkg::S_DONE;
				end else begin
					dist_d  = bla_pkg::LEVELS'(diff);
					node_d  = lower;
					lv_d    = bla_pkg::LVL_W'(bla_pkg::LEVELS - 1);
					state_d = bla_pkg::S_Q_LIFT;
				end
			end

			bla_pkg::S_Q_LIFT: begin
				// Take a jump for each set bit of the distance, highest first.
				if (dist_q[lv_q]) begin
					jreq.raddr = {node_q, lv_q};
					jzero_d    = (node_q == '0);
					state_d    = bla_pkg::S_Q_WAIT;
				end else if (lv_q == '0) begin
					state_d = bla_pkg::S_Q_CMP;
				end else begin
					lv_d = lv_q - bla_pkg::LVL_W'(1);
				end
			end

			bla_pkg::S_Q_WAIT: begin
				node_d = jdata;
				if (lv_q == '0) begin
					state_d = bla_pkg::S_Q_CMP;
				end else begin
					lv_d    = lv_q - bla_pkg::LVL_W'(1);
					state_d = bla_pkg::S_Q_LIFT;
				end
			end

			bla_pkg::S_Q_CMP: begin
				res_d.is_ancestor = (node_q == upper);
				state_d           = bla_pkg::S_DONE;
			end

			bla_pkg::S_DONE: begin
				if (res_ready) begin
					state_d = bla_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = bla_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/binary_lifting_ancestor_table_top.sv -----
// Top level of the binary lifting ancestor table: stream ports, memories and result register.
// Depends on bla_pkg, bla_ram and bla_ctrl.
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Payload
// s        in         s_tvalid/s_tready  s_tdata: action, upper_node, lower_node
// m        out        m_tvalid/m_tready  m_tdata: is_ancestor, new_node, status
//
// An insert steps through the jump levels in turn, each level fed by the
// registered read of the level below from the jump table.
// A query does two depth reads, then one jump table read and one update
// per set bit of the depth difference.
// Clear and undefined actions go straight to the result. No clearing pass after reset.
// The next item is accepted while a result still waits in the output register.

module binary_lifting_ancestor_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // action[1:0], upper_node[11:2], lower_node[21:12], zeros
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // is_ancestor[0], new_node[10:1], status[12:11], zeros
);

	bla_pkg::item_t                 item;
	bla_pkg::res_t                  res;
	bla_pkg::res_t                  out_res_q;
	logic                           out_valid_q;
	logic                           res_valid;
	logic                           res_ready;
	bla_pkg::jreq_t                 jreq;
	bla_pkg::dreq_t                 dreq;
	logic [bla_pkg::NODE_W-1:0]     jrdata;
	logic [bla_pkg::DEP_W-1:0]      drdata;

	assign item.action     = s_tdata[1:0];
	assign item.upper_node = s_tdata[11:2];
	assign item.lower_node = s_tdata[21:12];

	bla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.jreq      (jreq),
		.jrdata    (jrdata),
		.dreq      (dreq),
		.drdata    (drdata)
	);

	// Jump table: row per node, one entry per level.
	bla_ram #(
		.WIDTH (bla_pkg::NODE_W),
		.DEPTH (bla_pkg::JDEPTH)
	) u_jump_ram (
		.clk   (clk),
		.we    (jreq.we),
		.waddr (jreq.waddr),
		.wdata (jreq.wdata),
		.raddr (jreq.raddr),
		.rdata (jrdata)
	);

	// Depth of each node.
	bla_ram #(
		.WIDTH (bla_pkg::DEP_W),
		.DEPTH (bla_pkg::MAX_NODES)
	) u_depth_ram (
		.clk   (clk),
		.we    (dreq.we),
		.waddr (dreq.waddr),
		.wdata (dreq.wdata),
		.raddr (dreq.raddr),
		.rdata (drdata)
	);

	// Output register: refilled in the cycle it drains.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_res_q};

endmodule
